// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top module of the rational arithmetic core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A condition that must hold at every clock edge outside reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// A condition that must hold whenever a trigger is seen.
`define RAU_ASSERT_IMP(lbl, clk, rst_n, trig, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/rau_pkg.sv -----
// Types, codes and helper functions of the rational arithmetic core.
package rau_pkg;

    localparam int MAG_W = 32;

    // Action codes.
    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_ZDEN = 2'd3;

    // Start request for a bit-serial unit.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
    } t_ser_req;

    // Sign and magnitude to a 64-bit two's complement value.
    function automatic logic signed [63:0] to_s64(input logic sgn, input logic [MAG_W-1:0] mag);
        logic signed [63:0] v;
        v = $signed({32'd0, mag});
        return sgn ? -v : v;
    endfunction

endpackage

// ----- rtl/core/rau_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module rau_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_ser_req i_req,
    output logic              o_done,
    output logic [63:0]       o_prod
);
    logic [31:0] r_a;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] p_sum;

    // Partial sum of the upper half and the selected multiplicand.
    assign p_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 33'd0);

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= p_sum[32:1];
            r_lo <= {p_sum[0], r_lo[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

// ----- rtl/core/rau_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module rau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_ser_req i_req,
    output logic              o_done,
    output logic [31:0]       o_quot,
    output logic [31:0]       o_rem
);
    logic [31:0] r_d;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] p_part;
    logic        p_ge;
    logic [32:0] p_diff;

    // Trial subtraction of the divisor.
    assign p_part = {r_rem, r_q[31]};
    assign p_ge   = p_part >= {1'b0, r_d};
    assign p_diff = p_part - {1'b0, r_d};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_d   <= i_req.b;
            r_q   <= i_req.a;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= p_ge ? p_diff[31:0] : p_part[31:0];
            r_q   <= {r_q[30:0], p_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
// Rational arithmetic core: operand reduction, serial products, result reduction.
// The two operands and the result are each reduced by Euclid steps, each step a divider pass
// plus a check state. Six quotients and four products run on the serial divider and multiplier;
// compare has no result reduction. Unused actions and zero denominators go straight to the
// finish state. One item at a time.
// Synchronous active-low reset clears the sequencer and the output valid.
`include "assert_macros.svh"
module rational_arithmetic_unit_core #(
    parameter int WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // action[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
    input  logic [135:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_num[31:0], result_den[62:32], status[64:63], is_less[65],
    // is_greater[66], is_equal[67], zero fill
    output logic [71:0]  o_m_axis_tdata
);
    localparam int W = (WIDTH > 32) ? 32 : WIDTH;
    localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] LIM_LO = -LIM_HI - 64'sd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GCHK  = 4'd1;
    localparam logic [3:0] S_GDIV  = 4'd2;
    localparam logic [3:0] S_QN    = 4'd3;
    localparam logic [3:0] S_QD    = 4'd4;
    localparam logic [3:0] S_OPER  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_EVAL2 = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [1:0] SEL_A   = 2'd0;
    localparam logic [1:0] SEL_B   = 2'd1;
    localparam logic [1:0] SEL_RES = 2'd2;

    function automatic logic fits(input logic signed [63:0] v);
        return (v >= LIM_LO) && (v <= LIM_HI);
    endfunction

    logic [3:0]  r_state;
    logic        r_wait;
    logic [1:0]  r_nsel;
    logic [1:0]  r_pidx;
    logic [2:0]  r_act;
    logic [31:0] r_bn_in;
    logic [31:0] r_bd_in;
    // Reduction working registers.
    logic        r_nsgn;
    logic [31:0] r_xn;
    logic [31:0] r_xd;
    logic [31:0] r_ga;
    logic [31:0] r_gb;
    // Reduced operands, sign and magnitude.
    logic        r_as;
    logic [31:0] r_am;
    logic [31:0] r_adm;
    logic        r_bs;
    logic [31:0] r_bm;
    logic [31:0] r_bdm;
    logic signed [63:0] r_prod [4];
    logic signed [63:0] r_n64;
    logic signed [63:0] r_d64;
    logic        r_ok;
    // Result under construction.
    logic [31:0] r_rn;
    logic [30:0] r_rd;
    logic [1:0]  r_st;
    logic        r_lt;
    logic        r_gt;
    logic        r_eq;
    // Output register.
    logic        r_mvalid;
    logic [71:0] r_mdata;

    rau_pkg::t_ser_req p_mreq;
    rau_pkg::t_ser_req p_dreq;
    logic        p_mdone;
    logic [63:0] p_mprod;
    logic        p_ddone;
    logic [31:0] p_dquot;
    logic [31:0] p_drem;
    logic        p_msgn;
    logic        p_accept;
    logic [2:0]  p_act;
    logic [31:0] p_an;
    logic [31:0] p_ad;
    logic signed [63:0] p_nneg;
    logic signed [63:0] p_dneg;

    assign p_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign p_act    = i_s_axis_tdata[2:0];
    assign p_an     = i_s_axis_tdata[34:3];
    assign p_ad     = i_s_axis_tdata[66:35];
    assign p_nneg   = -r_n64;
    assign p_dneg   = -r_d64;

    // Operand selection for the four cross products.
    always_comb begin
        p_mreq.start = (r_state == S_MUL) && !r_wait;
        case (r_pidx)
            2'd0:    begin p_mreq.a = r_am;  p_mreq.b = r_bdm; p_msgn = r_as;        end
            2'd1:    begin p_mreq.a = r_adm; p_mreq.b = r_bm;  p_msgn = r_bs;        end
            2'd2:    begin p_mreq.a = r_adm; p_mreq.b = r_bdm; p_msgn = 1'b0;        end
            default: begin p_mreq.a = r_am;  p_mreq.b = r_bm;  p_msgn = r_as ^ r_bs; end
        endcase
    end

    // Divider requests: Euclid remainder steps and the two quotients by the gcd.
    always_comb begin
        p_dreq.start = !r_wait && ((r_state == S_GDIV) || (r_state == S_QN) ||
                                   (r_state == S_QD));
        p_dreq.a     = r_ga;
        p_dreq.b     = r_gb;
        if (r_state == S_QN) begin
            p_dreq.a = r_xn;
            p_dreq.b = r_ga;
        end else if (r_state == S_QD) begin
            p_dreq.a = r_xd;
            p_dreq.b = r_ga;
        end
    end

    rau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (p_mreq),
        .o_done  (p_mdone),
        .o_prod  (p_mprod)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (p_dreq),
        .o_done  (p_ddone),
        .o_quot  (p_dquot),
        .o_rem   (p_drem)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_nsel  <= SEL_A;
            r_pidx  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (p_accept) begin
                        r_act   <= p_act;
                        r_bn_in <= i_s_axis_tdata[98:67];
                        r_bd_in <= i_s_axis_tdata[130:99];
                        r_rn    <= '0;
                        r_rd    <= 31'd1;
                        r_st    <= rau_pkg::ST_OK;
                        r_lt    <= 1'b0;
                        r_gt    <= 1'b0;
                        r_eq    <= 1'b0;
                        r_nsgn  <= p_an[31] ^ p_ad[31];
                        r_xn    <= p_an[31] ? -p_an : p_an;
                        r_xd    <= p_ad[31] ? -p_ad : p_ad;
                        r_ga    <= p_an[31] ? -p_an : p_an;
                        r_gb    <= p_ad[31] ? -p_ad : p_ad;
                        r_nsel  <= SEL_A;
                        r_wait  <= 1'b0;
                        if (p_act > rau_pkg::ACT_CMP) begin
                            r_state <= S_FIN;
                        end else if (p_ad == 32'd0 || i_s_axis_tdata[130:99] == 32'd0) begin
                            r_st    <= rau_pkg::ST_ZDEN;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_GCHK;
                        end
                    end
                end
                S_GCHK: begin
                    r_state <= (r_gb == 32'd0) ? S_QN : S_GDIV;
                end
                S_GDIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (p_ddone) begin
                        r_wait  <= 1'b0;
                        r_ga    <= r_gb;
                        r_gb    <= p_drem;
                        r_state <= S_GCHK;
                    end
                end
                S_QN: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (p_ddone) begin
                        r_wait  <= 1'b0;
                        r_xn    <= p_dquot;
                        r_state <= S_QD;
                    end
                end
                S_QD: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (p_ddone) begin
                        r_wait <= 1'b0;
                        unique case (r_nsel)
                            SEL_A: begin
                                r_as    <= r_nsgn;
                                r_am    <= r_xn;
                                r_adm   <= p_dquot;
                                r_nsgn  <= r_bn_in[31] ^ r_bd_in[31];
                                r_xn    <= r_bn_in[31] ? -r_bn_in : r_bn_in;
                                r_xd    <= r_bd_in[31] ? -r_bd_in : r_bd_in;
                                r_ga    <= r_bn_in[31] ? -r_bn_in : r_bn_in;
                                r_gb    <= r_bd_in[31] ? -r_bd_in : r_bd_in;
                                r_nsel  <= SEL_B;
                                r_state <= S_GCHK;
                            end
                            SEL_B: begin
                                r_bs    <= r_nsgn;
                                r_bm    <= r_xn;
                                r_bdm   <= p_dquot;
                                r_state <= S_OPER;
                            end
                            default: begin
                                if (fits(rau_pkg::to_s64(r_nsgn, r_xn)) &&
                                    fits(rau_pkg::to_s64(1'b0, p_dquot))) begin
                                    r_rn <= r_nsgn ? -r_xn : r_xn;
                                    r_rd <= p_dquot[30:0];
                                end else begin
                                    r_st <= rau_pkg::ST_OVF;
                                end
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_OPER: begin
                    r_pidx <= 2'd0;
                    if (r_act == rau_pkg::ACT_CMP) begin
                        r_state <= S_MUL;
                    end else if (!fits(rau_pkg::to_s64(r_as, r_am)) ||
                                 !fits(rau_pkg::to_s64(1'b0, r_adm)) ||
                                 !fits(rau_pkg::to_s64(r_bs, r_bm)) ||
                                 !fits(rau_pkg::to_s64(1'b0, r_bdm))) begin
                        r_st    <= rau_pkg::ST_OVF;
                        r_state <= S_FIN;
                    end else if (r_act == rau_pkg::ACT_DIV && r_bm == 32'd0) begin
                        r_st    <= rau_pkg::ST_DIVZ;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (p_mdone) begin
                        r_wait          <= 1'b0;
                        r_prod[r_pidx]  <= p_msgn ? -$signed(p_mprod) : $signed(p_mprod);
                        r_pidx          <= r_pidx + 2'd1;
                        if (r_pidx == 2'd3) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_ok    <= 1'b1;
                    r_state <= S_EVAL2;
                    case (r_act)
                        rau_pkg::ACT_CMP: begin
                            r_lt    <= r_prod[0] < r_prod[1];
                            r_gt    <= r_prod[0] > r_prod[1];
                            r_eq    <= r_prod[0] == r_prod[1];
                            r_state <= S_FIN;
                        end
                        rau_pkg::ACT_MUL: begin
                            r_n64 <= r_prod[3];
                            r_d64 <= r_prod[2];
                        end
                        rau_pkg::ACT_DIV: begin
                            r_n64 <= r_prod[0];
                            r_d64 <= r_prod[1];
                        end
                        default: begin
                            r_n64 <= (r_act == rau_pkg::ACT_ADD) ? r_prod[0] + r_prod[1]
                                                                 : r_prod[0] - r_prod[1];
                            r_d64 <= r_prod[2];
                            r_ok  <= fits(r_prod[0]) && fits(r_prod[1]) && fits(r_prod[2]);
                        end
                    endcase
                end
                S_EVAL2: begin
                    if (r_ok && fits(r_n64) && fits(r_d64)) begin
                        r_nsgn  <= r_n64[63] ^ r_d64[63];
                        r_xn    <= r_n64[63] ? p_nneg[31:0] : r_n64[31:0];
                        r_xd    <= r_d64[63] ? p_dneg[31:0] : r_d64[31:0];
                        r_ga    <= r_n64[63] ? p_nneg[31:0] : r_n64[31:0];
                        r_gb    <= r_d64[63] ? p_dneg[31:0] : r_d64[31:0];
                        r_nsel  <= SEL_RES;
                        r_state <= S_GCHK;
                    end else begin
                        r_st    <= rau_pkg::ST_OVF;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_mvalid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded when the result request is finished and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == S_FIN && (!r_mvalid || i_m_axis_tready)) begin
            r_mvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_mvalid || i_m_axis_tready)) begin
            r_mdata <= {4'd0, r_eq, r_gt, r_lt, r_st, r_rd, r_rn};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;

    `RAU_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[62:32] != 31'd0)
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[64:63] != rau_pkg::ST_OK, o_m_axis_tdata[31:0] == 32'd0 && o_m_axis_tdata[62:32] == 31'd1)
    `RAU_ASSERT_IMP(a_flags_onehot0, i_clk, i_rst_n, r_mvalid, $onehot0(r_mdata[67:65]))
endmodule

// ----- verif/tb.sv -----
// Testbench of the rational arithmetic core: directed and random traffic checked against a built-in predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One fraction pair request and one result.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_frac_request;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
        logic        lt;
        logic        gt;
        logic        eq;
    } t_frac_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [135:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [71:0]  m_data;

    t_frac_request pending_requests[$];
    t_frac_result  expected_results[$];
    t_frac_request held_request;
    int            send_gap = 0;
    int            recv_stall = 0;
    int            sent_count = 0;
    int            checked_count = 0;
    int            error_count = 0;
    int            status_seen[4] = '{0, 0, 0, 0};
    bit            stimulus_done = 1'b0;

    rational_arithmetic_unit_core #(.WIDTH(32)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit fits_w(longint v);
        return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Move the sign to the numerator and cancel the common factor.
    function automatic void reduce_frac(inout longint n, inout longint d);
        longint unsigned g;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        g = euclid_gcd((n < 0) ? longint'(-n) : n, d);
        if (g == 0) g = 1;
        n = n / longint'(g);
        d = d / longint'(g);
    endfunction

    function automatic t_frac_result predict_rational(t_frac_request rq);
        t_frac_result r;
        longint an, ad, bn, bd, n, d, p, q;
        bit ok;
        an = longint'($signed(rq.a_num));
        ad = longint'($signed(rq.a_den));
        bn = longint'($signed(rq.b_num));
        bd = longint'($signed(rq.b_den));
        r = '{num: '0, den: 31'd1, status: rau_pkg::ST_OK, lt: 1'b0, gt: 1'b0, eq: 1'b0};
        if (rq.action > rau_pkg::ACT_CMP) return r;
        if (ad == 0 || bd == 0) begin
            r.status = rau_pkg::ST_ZDEN;
            return r;
        end
        reduce_frac(an, ad);
        reduce_frac(bn, bd);
        if (rq.action == rau_pkg::ACT_CMP) begin
            p = an * bd;
            q = ad * bn;
            r.lt = p < q;
            r.gt = p > q;
            r.eq = p == q;
            return r;
        end
        if (!fits_w(an) || !fits_w(ad) || !fits_w(bn) || !fits_w(bd)) begin
            r.status = rau_pkg::ST_OVF;
            return r;
        end
        if (rq.action == rau_pkg::ACT_DIV && bn == 0) begin
            r.status = rau_pkg::ST_DIVZ;
            return r;
        end
        if (rq.action == rau_pkg::ACT_MUL) begin
            n = an * bn;
            d = ad * bd;
            ok = fits_w(n) && fits_w(d);
        end else if (rq.action == rau_pkg::ACT_DIV) begin
            n = an * bd;
            d = ad * bn;
            ok = fits_w(n) && fits_w(d);
        end else begin
            p = an * bd;
            q = ad * bn;
            d = ad * bd;
            n = 0;
            ok = fits_w(p) && fits_w(q) && fits_w(d);
            if (ok) begin
                n = (rq.action == rau_pkg::ACT_ADD) ? p + q : p - q;
                ok = fits_w(n);
            end
        end
        if (ok) begin
            reduce_frac(n, d);
            ok = fits_w(n) && fits_w(d);
        end
        if (ok) begin
            r.num = n[31:0];
            r.den = d[30:0];
        end else begin
            r.status = rau_pkg::ST_OVF;
        end
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return 32'($signed($urandom_range(0, 200)) - 100);
            4, 5:       return 32'($signed($urandom_range(0, 200000)) - 100000);
            6:          begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
            default:    return $urandom();
        endcase
    endfunction

    task automatic add_request(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
        t_frac_request rq;
        rq = '{action: act, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        pending_requests.push_back(rq);
    endtask

    // Sender: present requests from the pending queue, with random gaps except in every third run of 64.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            expected_results.push_back(predict_rational(held_request));
            sent_count <= sent_count + 1;
            s_valid <= 1'b0;
            send_gap <= ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 17);
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() > 0) begin
                held_request = pending_requests.pop_front();
                s_data <= {5'd0, held_request.b_den, held_request.b_num,
                           held_request.a_den, held_request.a_num, held_request.action};
                s_valid <= 1'b1;
            end
        end
    end

    // Receiver: check each result against the oldest expectation, stall at random except in every third run of 80.
    always @(posedge i_clk) begin
        t_frac_result want;
        t_frac_result got;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            got = '{num: m_data[31:0], den: m_data[62:32], status: m_data[64:63],
                    lt: m_data[65], gt: m_data[66], eq: m_data[67]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
                         $signed(got.num), got.den, got.status);
                error_count <= error_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected num=%0d den=%0d st=%0d lt=%b gt=%b eq=%b",
                             $time, $signed(want.num), want.den, want.status,
                             want.lt, want.gt, want.eq);
                    $display("%0t:          actual num=%0d den=%0d st=%0d lt=%b gt=%b eq=%b",
                             $time, $signed(got.num), got.den, got.status,
                             got.lt, got.gt, got.eq);
                    error_count <= error_count + 1;
                end
                status_seen[want.status] <= status_seen[want.status] + 1;
            end
            checked_count <= checked_count + 1;
            m_ready <= 1'b0;
            recv_stall <= ((checked_count / 80) % 3 == 1) ? 0 : $urandom_range(0, 17);
        end else if (!m_ready) begin
            if (recv_stall > 0) recv_stall <= recv_stall - 1;
            else m_ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial begin
        int act_pick;
        logic [2:0] act;
        logic [31:0] ad, bd;
        // Directed cases.
        add_request(rau_pkg::ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        add_request(rau_pkg::ACT_SUB, 32'd1, 32'd2, 32'd3, 32'd4);
        add_request(rau_pkg::ACT_MUL, -32'sd2, 32'd3, 32'd9, -32'sd4);
        add_request(rau_pkg::ACT_DIV, 32'd5, 32'd7, -32'sd10, 32'd21);
        add_request(rau_pkg::ACT_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
        add_request(rau_pkg::ACT_CMP, -32'sd1, 32'd3, 32'd1, 32'd3);
        add_request(rau_pkg::ACT_CMP, 32'd7, 32'd3, 32'd2, 32'd1);
        add_request(rau_pkg::ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        add_request(rau_pkg::ACT_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
        add_request(rau_pkg::ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        add_request(rau_pkg::ACT_ADD, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
        add_request(rau_pkg::ACT_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        add_request(rau_pkg::ACT_CMP, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'd1);
        add_request(rau_pkg::ACT_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        add_request(rau_pkg::ACT_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        add_request(rau_pkg::ACT_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        add_request(rau_pkg::ACT_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
        add_request(rau_pkg::ACT_MUL, 32'd0, 32'd5, 32'h8000_0000, 32'd1);
        add_request(rau_pkg::ACT_SUB, 32'h8000_0000, 32'd2, 32'h8000_0000, 32'd2);
        add_request(rau_pkg::ACT_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        add_request(3'd5, 32'd1, 32'd0, 32'd1, 32'd0);
        add_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_request(3'd6, 32'd3, 32'd4, 32'd5, 32'd6);
        // Random cases, mostly valid actions with nonzero denominators.
        repeat (1000) begin
            act_pick = $urandom_range(0, 99);
            act = (act_pick < 95) ? 3'(act_pick % 5) : 3'($urandom_range(5, 7));
            ad = random_operand();
            bd = random_operand();
            if ($urandom_range(0, 19) != 0) begin
                if (ad == 0) ad = 32'd1;
                if (bd == 0) bd = 32'hffff_ffff;
            end
            add_request(act, random_operand(), ad, random_operand(), bd);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results over %0d requests: ok %0d, overflow %0d,",
                 checked_count, sent_count, status_seen[0], status_seen[1]);
        $display("divide by zero %0d, zero denominator %0d.", status_seen[2], status_seen[3]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Timeout well beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("tb NOT OK");
        $finish;
    end
endmodule
